// ===== design/wf3_pkg.sv =====
package wf3_pkg;

  // Field and register widths
  localparam int unsigned PIX_W     = 16;
  localparam int unsigned COEF_W    = 8;
  localparam int unsigned PROD_W    = PIX_W + COEF_W;
  localparam int unsigned OUT_W     = 27;
  localparam int unsigned COLS_W    = 11;
  localparam int unsigned ROWS_W    = 13;
  localparam int unsigned KROW_W    = 3 * COEF_W;
  localparam int unsigned CFG_W     = 24;
  localparam int unsigned CFG_IDX_W = 3;

  // Image limits and line store geometry
  localparam int unsigned MAX_COLS = 1024;
  localparam int unsigned MAX_ROWS = 4096;
  localparam int unsigned ADDR_W   = $clog2(MAX_COLS);
  localparam int unsigned LINE_W   = 2 * PIX_W;

  // Register reset values
  localparam logic [COLS_W-1:0] COLS_RESET = COLS_W'(640);
  localparam logic [ROWS_W-1:0] ROWS_RESET = ROWS_W'(480);
  localparam logic [KROW_W-1:0] KTOP_RESET = KROW_W'(65791);
  localparam logic [KROW_W-1:0] KMID_RESET = KROW_W'(131326);
  localparam logic [KROW_W-1:0] KBOT_RESET = KROW_W'(65791);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_COLS  = 3'd0,
    REG_IMAGE_ROWS  = 3'd1,
    REG_KERNEL_TOP  = 3'd2,
    REG_KERNEL_MID  = 3'd3,
    REG_KERNEL_BOT  = 3'd4
  } wf3_reg_e;

  // Per-cycle control handed to every cell of the chain
  typedef struct packed {
    logic load;   // capture products of the column leaving the read stage
    logic step;   // fold products and neighbour partial sum into the cell register
    logic clear;  // item starts an output row: ignore the neighbour partial sum
  } wf3_cell_ctrl_t;

endpackage

// ===== design/wf3_line_store.sv =====
module wf3_line_store (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [wf3_pkg::ADDR_W-1:0] waddr_i,
  input  logic [wf3_pkg::LINE_W-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [wf3_pkg::ADDR_W-1:0] raddr_i,
  output logic [wf3_pkg::LINE_W-1:0] rdata_o
);
  import wf3_pkg::*;

  logic [LINE_W-1:0] mem_q [MAX_COLS];
  logic [LINE_W-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, held while no new read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/wf3_cell.sv =====
module wf3_cell (
  input  logic                                 clk_i,
  input  wf3_pkg::wf3_cell_ctrl_t              ctrl_i,
  input  logic [2:0][wf3_pkg::PIX_W-1:0]       pix_col_i,
  input  logic [2:0][wf3_pkg::COEF_W-1:0]      coef_col_i,
  input  logic signed [wf3_pkg::OUT_W-1:0]     psum_i,
  output logic signed [wf3_pkg::OUT_W-1:0]     psum_o
);
  import wf3_pkg::*;

  logic signed [PROD_W-1:0] prod_q [3];
  logic signed [OUT_W-1:0]  acc_q;
  logic signed [OUT_W-1:0]  acc_d;

  // Multiply the incoming column by this cell's kernel column
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      for (int k = 0; k < 3; k++) begin
        prod_q[k] <= $signed(pix_col_i[k]) * $signed(coef_col_i[k]);
      end
    end
  end

  // Add the column sum to the partial sum handed over by the neighbour
  always_comb begin
    acc_d = ctrl_i.clear ? '0 : psum_i;
    for (int k = 0; k < 3; k++) begin
      acc_d = acc_d + OUT_W'(prod_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.step) begin
      acc_q <= acc_d;
    end
  end

  assign psum_o = acc_q;

endmodule

// ===== design/window_filter_3x3_full.sv =====
// 3x3 zero-padded window filter over a pixel stream, full-size output grid.
// Input channel: one beat per output position of the (rows+2) x (cols+2) grid,
// in raster order; pixel_value_i is ignored outside the image.
// Output channel: one beat per input beat with the exact 27-bit weighted sum,
// row_end_o on the last column of each output row and frame_end_o on the last
// position of the frame.
// Configuration: write cfg_data_i to register cfg_idx_i while cfg_we_i is high;
// index 0 width, 1 height, 2..4 kernel rows. Write only while the block is idle.
// A result passes the read stage, cell product and cell accumulator registers.
// Throughput: one beat per cycle while the output is not stalled, through the
// three-stage pipe of line store read, cell multiply and cell accumulate.
// A stall on the output holds the result register; further beats are still
// taken until the internal stages have filled, then in_stall_o rises.
// Reset clears the position counters and pipe valid bits and loads 640x480
// with the -1,0,1 / -2,0,2 / -1,0,1 kernel. Line store contents are not
// cleared: an entry is only read after the current frame has written it.
module window_filter_3x3_full (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [wf3_pkg::PIX_W-1:0]    pixel_value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [wf3_pkg::OUT_W-1:0]    filtered_value_o,
  output logic                                row_end_o,
  output logic                                frame_end_o,
  input  logic                                cfg_we_i,
  input  logic [wf3_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [wf3_pkg::CFG_W-1:0]           cfg_data_i
);
  import wf3_pkg::*;

  // Configuration registers
  logic [COLS_W-1:0]      cols_q;
  logic [ROWS_W-1:0]      rows_q;
  logic [2:0][KROW_W-1:0] kern_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q    <= COLS_RESET;
      rows_q    <= ROWS_RESET;
      kern_q[0] <= KTOP_RESET;
      kern_q[1] <= KMID_RESET;
      kern_q[2] <= KBOT_RESET;
    end else if (cfg_we_i) begin
      case (wf3_reg_e'(cfg_idx_i))
        REG_IMAGE_COLS: cols_q    <= cfg_data_i[COLS_W-1:0];
        REG_IMAGE_ROWS: rows_q    <= cfg_data_i[ROWS_W-1:0];
        REG_KERNEL_TOP: kern_q[0] <= cfg_data_i[KROW_W-1:0];
        REG_KERNEL_MID: kern_q[1] <= cfg_data_i[KROW_W-1:0];
        REG_KERNEL_BOT: kern_q[2] <= cfg_data_i[KROW_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the image size to the supported range
  logic [COLS_W-1:0] cols_c;
  logic [ROWS_W-1:0] rows_c;

  always_comb begin
    if (cols_q == '0) begin
      cols_c = COLS_W'(1);
    end else if (cols_q > COLS_W'(MAX_COLS)) begin
      cols_c = COLS_W'(MAX_COLS);
    end else begin
      cols_c = cols_q;
    end
    if (rows_q == '0) begin
      rows_c = ROWS_W'(1);
    end else if (rows_q > ROWS_W'(MAX_ROWS)) begin
      rows_c = ROWS_W'(MAX_ROWS);
    end else begin
      rows_c = rows_q;
    end
  end

  // Pipe handshake: each stage moves on when the one after it is free
  logic s1_vld_q, s2_vld_q, out_vld_q;
  logic out_free, s2_free, s1_free;
  logic s1_adv, s2_adv, in_acc;

  assign out_free = !out_vld_q || !out_stall_i;
  assign s2_adv   = s2_vld_q && out_free;
  assign s2_free  = !s2_vld_q || out_free;
  assign s1_adv   = s1_vld_q && s2_free;
  assign s1_free  = !s1_vld_q || s2_free;
  assign in_acc   = in_valid_i && s1_free;

  assign in_stall_o = !s1_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_vld_q <= in_valid_i;
      end
      if (s2_free) begin
        s2_vld_q <= s1_adv;
      end
      if (out_free) begin
        out_vld_q <= s2_adv;
      end
    end
  end

  // Output grid position
  logic [ROWS_W-1:0] row_q;
  logic [COLS_W-1:0] col_q;
  logic              last_col, last_row;

  assign last_col = col_q >= (cols_c + COLS_W'(1));
  assign last_row = row_q >= (rows_c + ROWS_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (in_acc) begin
      if (last_col) begin
        col_q <= '0;
        row_q <= last_row ? '0 : row_q + ROWS_W'(1);
      end else begin
        col_q <= col_q + COLS_W'(1);
      end
    end
  end

  // Decide which window taps come from inside the image
  logic col_in, bot_in, mid_in, top_in;

  assign col_in = col_q < cols_c;
  assign bot_in = col_in && (row_q < rows_c);
  assign mid_in = col_in && (row_q != '0) && (row_q <= rows_c);
  assign top_in = col_in && (row_q >= ROWS_W'(2)) && (row_q <= rows_c + ROWS_W'(1));

  // Read stage: capture the beat and read both stored lines from the line store at its column
  logic signed [PIX_W-1:0] s1_pix_q;
  logic [ADDR_W-1:0]       s1_addr_q;
  logic                    s1_col_q, s1_bot_q, s1_mid_q, s1_top_q;
  logic                    s1_clr_q, s1_rend_q, s1_fend_q;
  logic [LINE_W-1:0]       line_rd;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_pix_q  <= pixel_value_i;
      s1_addr_q <= col_q[ADDR_W-1:0];
      s1_col_q  <= col_in;
      s1_bot_q  <= bot_in;
      s1_mid_q  <= mid_in;
      s1_top_q  <= top_in;
      s1_clr_q  <= (col_q == '0);
      s1_rend_q <= last_col;
      s1_fend_q <= last_col && last_row;
    end
  end

  // Gate taps outside the image to zero
  logic [2:0][PIX_W-1:0] col_pix;

  assign col_pix[0] = s1_top_q ? line_rd[LINE_W-1:PIX_W] : '0;
  assign col_pix[1] = s1_mid_q ? line_rd[PIX_W-1:0]      : '0;
  assign col_pix[2] = s1_bot_q ? s1_pix_q                : '0;

  // Shift the column down a line: middle moves to upper, new pixel to middle
  wf3_line_store u_line_store (
    .clk_i   (clk_i),
    .we_i    (s1_adv && s1_col_q),
    .waddr_i (s1_addr_q),
    .wdata_i ({col_pix[1], col_pix[2]}),
    .re_i    (in_acc),
    .raddr_i (col_q[ADDR_W-1:0]),
    .rdata_o (line_rd)
  );

  // Multiply stage flags
  logic s2_clr_q, s2_rend_q, s2_fend_q;

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_clr_q  <= s1_clr_q;
      s2_rend_q <= s1_rend_q;
      s2_fend_q <= s1_fend_q;
    end
  end

  wf3_cell_ctrl_t cell_ctrl;

  assign cell_ctrl.load  = s1_adv;
  assign cell_ctrl.step  = s2_adv;
  assign cell_ctrl.clear = s2_clr_q;

  // Chain of three cells, one per kernel column; the last one holds the result
  logic signed [OUT_W-1:0] psum [4];

  assign psum[0] = '0;

  for (genvar l = 0; l < 3; l++) begin : g_cell
    logic [2:0][COEF_W-1:0] coef_col;

    for (genvar k = 0; k < 3; k++) begin : g_coef
      assign coef_col[k] = kern_q[k][COEF_W*l +: COEF_W];
    end

    wf3_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (cell_ctrl),
      .pix_col_i  (col_pix),
      .coef_col_i (coef_col),
      .psum_i     (psum[l]),
      .psum_o     (psum[l+1])
    );
  end

  // Result flags, aligned with the last cell's register
  logic out_rend_q, out_fend_q;

  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      out_rend_q <= s2_rend_q;
      out_fend_q <= s2_fend_q;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign filtered_value_o = psum[3];
  assign row_end_o        = out_rend_q;
  assign frame_end_o      = out_fend_q;

endmodule
